FILE: design/agb_pkg.sv
`default_nettype none

package agb_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_DIV,
    ST_MUL,
    ST_LOAD
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic div_step;
    logic mul;
    logic out_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;
    logic mask_empty;
    logic div_last;
    logic out_room;
  } status_t;

  typedef struct packed {
    logic [15:0] fg_rgb;
    logic [15:0] bg_rgb;
    logic [1:0]  bpp_log2;
    logic [7:0]  gray_level;
    logic [7:0]  glyph_width;
    logic [7:0]  frame_width;
    logic [7:0]  glyph_rows;
  } cfg_t;

  localparam logic [2:0] REG_FG_RGB      = 3'd0;
  localparam logic [2:0] REG_BG_RGB      = 3'd1;
  localparam logic [2:0] REG_BPP_LOG2    = 3'd2;
  localparam logic [2:0] REG_GRAY_LEVEL  = 3'd3;
  localparam logic [2:0] REG_GLYPH_WIDTH = 3'd4;
  localparam logic [2:0] REG_FRAME_WIDTH = 3'd5;
  localparam logic [2:0] REG_GLYPH_ROWS  = 3'd6;

  localparam logic [31:0] RB_MASK    = 32'h07E0F81F;
  localparam logic [7:0]  ALPHA_FORE = 8'hF8;
  localparam logic [7:0]  ALPHA_BACK = 8'h08;
  localparam logic [8:0]  ROW_MAX    = 9'd511;

endpackage

`default_nettype wire

FILE: design/agb_ctrl.sv
`default_nettype none

module agb_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire agb_pkg::status_t status,
  output agb_pkg::cmd_t         cmd
);

  agb_pkg::state_t state_r;
  agb_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= agb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      agb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = agb_pkg::ST_SCAN;
      end
      agb_pkg::ST_SCAN: begin
        if (status.scan_last) state_nxt = agb_pkg::ST_PICK;
      end
      agb_pkg::ST_PICK: begin
        state_nxt = status.mask_empty ? agb_pkg::ST_IDLE : agb_pkg::ST_DIV;
      end
      agb_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = agb_pkg::ST_MUL;
      end
      agb_pkg::ST_MUL: begin
        state_nxt = agb_pkg::ST_LOAD;
      end
      agb_pkg::ST_LOAD: begin
        if (status.out_room) state_nxt = agb_pkg::ST_PICK;
      end
      default: begin
        state_nxt = agb_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      agb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      agb_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      agb_pkg::ST_PICK: begin
        cmd.pick = !status.mask_empty;
      end
      agb_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      agb_pkg::ST_MUL: begin
        cmd.mul = 1'b1;
      end
      agb_pkg::ST_LOAD: begin
        cmd.out_load = status.out_room;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/agb_dp.sv
`default_nettype none

module agb_dp (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire agb_pkg::cfg_t    cfg,
  input  wire agb_pkg::cmd_t    cmd,
  output agb_pkg::status_t      status,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_glyph_start,
  input  wire logic [11:0]      in_origin_x,
  input  wire logic [11:0]      in_origin_y,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [12:0]           out_pixel_x,
  output logic [12:0]           out_pixel_y,
  output logic [15:0]           out_color,
  output logic                  out_last
);

  // request latch
  logic [7:0]  data_r;
  logic [11:0] ox_r;
  logic [11:0] oy_r;

  // position counters and slot scan
  logic [7:0]  col_r;
  logic [8:0]  row_r;
  logic [2:0]  k_r;
  logic [7:0]  mask_r;
  logic [12:0] x_at_r [8];
  logic [12:0] y_at_r [8];

  // current pixel
  logic [12:0] cur_x_r;
  logic [12:0] cur_y_r;
  logic        cur_last_r;

  // divider
  logic [15:0] dvd_r;
  logic [7:0]  rem_r;
  logic [7:0]  q_r;
  logic [1:0]  step_r;
  logic [15:0] dvd_nxt;
  logic [7:0]  rem_nxt;
  logic [7:0]  q_nxt;
  logic [8:0]  trial;

  // blend
  logic [31:0] prod_r;

  // output register
  logic        out_valid_r;
  logic [12:0] out_x_r;
  logic [12:0] out_y_r;
  logic [15:0] out_color_r;
  logic        out_last_r;

  logic [2:0]  slots_last;
  logic [7:0]  vmask;
  logic [7:0]  vis_w;
  logic        visible;
  logic [8:0]  col_inc;
  logic        row_wrap;
  logic [7:0]  col_nxt;
  logic [8:0]  row_nxt;
  logic [2:0]  pick_idx;
  logic [7:0]  mask_cleared;
  logic [2:0]  sh;
  logic [7:0]  pix_v;
  logic [15:0] dividend;
  logic [7:0]  divisor;
  logic [31:0] v1;
  logic [31:0] v2;
  logic [31:0] diff;
  logic [31:0] v3;
  logic [15:0] blend_color;
  logic [15:0] color_sel;

  always_comb begin
    case (cfg.bpp_log2)
      2'd0:    begin slots_last = 3'd7; vmask = 8'h01; end
      2'd1:    begin slots_last = 3'd3; vmask = 8'h03; end
      2'd2:    begin slots_last = 3'd1; vmask = 8'h0F; end
      default: begin slots_last = 3'd0; vmask = 8'hFF; end
    endcase
  end

  assign vis_w    = (cfg.glyph_width < cfg.frame_width) ? cfg.glyph_width : cfg.frame_width;
  assign visible  = (row_r < {1'b0, cfg.glyph_rows}) && (col_r < vis_w);
  assign col_inc  = {1'b0, col_r} + 9'd1;
  // zero frame width wraps on every slot
  assign row_wrap = col_inc >= {1'b0, cfg.frame_width};
  assign col_nxt  = row_wrap ? 8'd0 : col_inc[7:0];
  assign row_nxt  = (row_wrap && row_r != agb_pkg::ROW_MAX) ? row_r + 9'd1 : row_r;

  // lowest pending slot
  always_comb begin
    pick_idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (mask_r[i]) pick_idx = 3'(i);
    end
  end

  assign mask_cleared = mask_r & ~(8'd1 << pick_idx);
  assign sh           = pick_idx << cfg.bpp_log2;
  assign pix_v        = (data_r >> sh) & vmask;
  assign dividend     = {pix_v, 8'h00} - {8'h00, pix_v};
  assign divisor      = (cfg.gray_level >= 8'd2) ? cfg.gray_level - 8'd1 : 8'd1;

  // four restoring steps per cycle; low 8 quotient bits are all that matter
  always_comb begin
    dvd_nxt = dvd_r;
    rem_nxt = rem_r;
    q_nxt   = q_r;
    trial   = '0;
    for (int i = 0; i < 4; i++) begin
      trial   = {rem_nxt, dvd_nxt[15]};
      dvd_nxt = {dvd_nxt[14:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = 8'(trial - {1'b0, divisor});
        q_nxt   = {q_nxt[6:0], 1'b1};
      end else begin
        rem_nxt = trial[7:0];
        q_nxt   = {q_nxt[6:0], 1'b0};
      end
    end
  end

  assign v1          = {cfg.bg_rgb, cfg.bg_rgb} & agb_pkg::RB_MASK;
  assign v2          = {cfg.fg_rgb, cfg.fg_rgb} & agb_pkg::RB_MASK;
  assign diff        = v2 - v1;
  assign v3          = ((prod_r >> 5) + v1) & agb_pkg::RB_MASK;
  assign blend_color = v3[15:0] | v3[31:16];

  always_comb begin
    if (q_r >= agb_pkg::ALPHA_FORE) begin
      color_sel = cfg.fg_rgb;
    end else if (q_r < agb_pkg::ALPHA_BACK) begin
      color_sel = cfg.bg_rgb;
    end else begin
      color_sel = blend_color;
    end
  end

  assign status.scan_last  = (k_r == slots_last);
  assign status.mask_empty = (mask_r == 8'd0);
  assign status.div_last   = (step_r == 2'd3);
  assign status.out_room   = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      k_r         <= '0;
      mask_r      <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        k_r    <= '0;
        mask_r <= '0;
        if (in_glyph_start) begin
          col_r <= '0;
          row_r <= '0;
        end
      end
      if (cmd.scan) begin
        mask_r[k_r] <= visible;
        k_r         <= k_r + 3'd1;
        col_r       <= col_nxt;
        row_r       <= row_nxt;
      end
      if (cmd.pick) begin
        mask_r <= mask_cleared;
        step_r <= '0;
      end
      if (cmd.div_step) step_r <= step_r + 2'd1;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      data_r <= in_data_byte;
      ox_r   <= in_origin_x;
      oy_r   <= in_origin_y;
    end
    if (cmd.scan) begin
      x_at_r[k_r] <= {1'b0, ox_r} + {5'd0, col_r};
      y_at_r[k_r] <= {1'b0, oy_r} + {4'd0, row_r};
    end
    if (cmd.pick) begin
      cur_x_r    <= x_at_r[pick_idx];
      cur_y_r    <= y_at_r[pick_idx];
      cur_last_r <= (mask_cleared == 8'd0);
      dvd_r      <= dividend;
      rem_r      <= '0;
      q_r        <= '0;
    end
    if (cmd.div_step) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
    if (cmd.mul) begin
      prod_r <= diff * {27'd0, q_r[7:3]};
    end
    if (cmd.out_load) begin
      out_x_r     <= cur_x_r;
      out_y_r     <= cur_y_r;
      out_color_r <= color_sel;
      out_last_r  <= cur_last_r;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_x_r;
  assign out_pixel_y = out_y_r;
  assign out_color   = out_color_r;
  assign out_last    = out_last_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  a_pick_pending: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick |-> mask_r != 8'd0)
    else $error("pick with no pending slot");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> k_r <= slots_last)
    else $error("scan past last slot");

  a_div_steps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> step_r == 2'd0)
    else $error("divider did not run all steps");

  a_fore_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_load && q_r >= agb_pkg::ALPHA_FORE) |=> out_color_r == $past(cfg.fg_rgb))
    else $error("saturated alpha not foreground");

endmodule

`default_nettype wire

FILE: design/antialiased_glyph_pixel_blender.sv
`default_nettype none

// Channel  Ports                                           Handshake
// input    in_data_byte, in_glyph_start, in_origin_x/y     in_valid / in_stall
// output   out_pixel_x/y, out_color, out_last              out_valid / out_stall
// config   cfg_index, cfg_data                             cfg_we, no wait
//
// One request: an accept step, one scan step per pixel slot (8 >> bpp_log2),
// then per visible pixel a pick, the divider steps, a multiply and a load, and
// a closing pick that finds no pixel left. The 4-bit-per-cycle alpha divider
// is the longest part of each pixel. Synchronous active-low reset restores the
// register defaults and zeroes the column/row counters. A stalled result holds
// the load step; a new request is taken while the last result waits.

module antialiased_glyph_pixel_blender (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_glyph_start,
  input  wire logic [11:0] in_origin_x,
  input  wire logic [11:0] in_origin_y,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [12:0]      out_pixel_x,
  output logic [12:0]      out_pixel_y,
  output logic [15:0]      out_color,
  output logic             out_last
);

  agb_pkg::cfg_t    cfg_r;
  agb_pkg::cmd_t    cmd;
  agb_pkg::status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_rgb      <= 16'hFFFF;
      cfg_r.bg_rgb      <= 16'h0000;
      cfg_r.bpp_log2    <= 2'd0;
      cfg_r.gray_level  <= 8'd2;
      cfg_r.glyph_width <= 8'd16;
      cfg_r.frame_width <= 8'd16;
      cfg_r.glyph_rows  <= 8'd16;
    end else if (cfg_we) begin
      case (cfg_index)
        agb_pkg::REG_FG_RGB:      cfg_r.fg_rgb      <= cfg_data;
        agb_pkg::REG_BG_RGB:      cfg_r.bg_rgb      <= cfg_data;
        agb_pkg::REG_BPP_LOG2:    cfg_r.bpp_log2    <= cfg_data[1:0];
        agb_pkg::REG_GRAY_LEVEL:  cfg_r.gray_level  <= cfg_data[7:0];
        agb_pkg::REG_GLYPH_WIDTH: cfg_r.glyph_width <= cfg_data[7:0];
        agb_pkg::REG_FRAME_WIDTH: cfg_r.frame_width <= cfg_data[7:0];
        agb_pkg::REG_GLYPH_ROWS:  cfg_r.glyph_rows  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  agb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  agb_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .cmd            (cmd),
    .status         (status),
    .in_data_byte   (in_data_byte),
    .in_glyph_start (in_glyph_start),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_color      (out_color),
    .out_last       (out_last)
  );

endmodule

`default_nettype wire

FILE: tb/tb_antialiased_glyph_pixel_blender.sv
module tb_antialiased_glyph_pixel_blender;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int SETTLE_CYCLES = 80;
  localparam int GROUP_PIXEL_BYTES = 4;
  localparam int GROUP_MAX_BYTES = 6;

  typedef struct {
    logic [12:0] x;
    logic [12:0] y;
    logic [15:0] color;
    logic        last;
  } pixel_t;

  class glyph_pixel_scoreboard;
    agb_pkg::cfg_t regs = '{fg_rgb: 16'hFFFF, bg_rgb: 16'h0000, bpp_log2: 2'd0,
                            gray_level: 8'd2, glyph_width: 8'd16, frame_width: 8'd16,
                            glyph_rows: 8'd16};
    logic [7:0] col = 8'd0;
    logic [8:0] row = 9'd0;
    pixel_t     pending_pixels[$];
    int         errors = 0;

    function logic [15:0] mix_rgb565(logic [15:0] bg, logic [15:0] fg, logic [7:0] alpha);
      logic [31:0] bg_spread;
      logic [31:0] fg_spread;
      logic [31:0] mixed;
      logic [31:0] weight;
      if (alpha >= agb_pkg::ALPHA_FORE) return fg;
      if (alpha < agb_pkg::ALPHA_BACK) return bg;
      bg_spread = ({16'h0, bg} | {bg, 16'h0}) & agb_pkg::RB_MASK;
      fg_spread = ({16'h0, fg} | {fg, 16'h0}) & agb_pkg::RB_MASK;
      weight = {27'h0, alpha[7:3]};
      mixed = ((((fg_spread - bg_spread) * weight) >> 5) + bg_spread) & agb_pkg::RB_MASK;
      return mixed[15:0] | mixed[31:16];
    endfunction

    // Returns how many pixels this byte yields.
    function int note_byte(logic [7:0] data, logic start, logic [11:0] ox, logic [11:0] oy);
      int unsigned bits;
      int unsigned slots;
      int unsigned vis;
      int unsigned divisor;
      int unsigned v;
      int unsigned alpha;
      int          k;
      int          n;
      pixel_t      p;
      pixel_t      held;
      bit          have_held;
      bits = 1 << regs.bpp_log2;
      slots = 8 >> regs.bpp_log2;
      vis = (regs.glyph_width < regs.frame_width) ? regs.glyph_width : regs.frame_width;
      divisor = (regs.gray_level >= 2) ? regs.gray_level - 1 : 1;
      n = 0;
      have_held = 1'b0;
      if (start) begin
        col = 8'd0;
        row = 9'd0;
      end
      for (k = 0; k < slots; k++) begin
        v = (data >> (k * bits)) & ((1 << bits) - 1);
        if (row < {1'b0, regs.glyph_rows} && col < vis) begin
          alpha = ((255 * v) / divisor) & 8'hFF;
          p.x = {1'b0, ox} + {5'h0, col};
          p.y = {1'b0, oy} + {4'h0, row};
          p.color = mix_rgb565(regs.bg_rgb, regs.fg_rgb, alpha[7:0]);
          p.last = 1'b0;
          if (have_held) pending_pixels.push_back(held);
          held = p;
          have_held = 1'b1;
          n++;
        end
        if (int'(col) + 1 >= int'(regs.frame_width)) begin
          col = 8'd0;
          if (row < agb_pkg::ROW_MAX) row = row + 9'd1;
        end else begin
          col = col + 8'd1;
        end
      end
      if (have_held) begin
        held.last = 1'b1;
        pending_pixels.push_back(held);
      end
      return n;
    endfunction

    function void check_pixel(logic [12:0] x, logic [12:0] y, logic [15:0] color, logic last);
      pixel_t e;
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel x=%0d y=%0d color=%h last=%b", x, y, color, last);
        errors++;
        return;
      end
      e = pending_pixels.pop_front();
      if (x !== e.x) begin
        $error("pixel_x: expected %0d, got %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("pixel_y: expected %0d, got %0d", e.y, y);
        errors++;
      end
      if (color !== e.color) begin
        $error("color: expected %h, got %h", e.color, color);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %b, got %b", e.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = agb_pkg::REG_FG_RGB;
  logic [15:0] cfg_data = 16'h0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'h0;
  logic        in_glyph_start = 1'b0;
  logic [11:0] in_origin_x = 12'h0;
  logic [11:0] in_origin_y = 12'h0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [12:0] out_pixel_x;
  logic [12:0] out_pixel_y;
  logic [15:0] out_color;
  logic        out_last;

  glyph_pixel_scoreboard sb = new;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  antialiased_glyph_pixel_blender u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_glyph_start (in_glyph_start),
    .in_origin_x    (in_origin_x),
    .in_origin_y    (in_origin_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pixel_x    (out_pixel_x),
    .out_pixel_y    (out_pixel_y),
    .out_color      (out_color),
    .out_last       (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Pixel sink: check accepted pixels, then choose next cycle's stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_pixel(out_pixel_x, out_pixel_y, out_color, out_last);
    out_stall <= (int'($urandom_range(99)) < recv_stall_pct);
  end

  function automatic agb_pkg::cfg_t settings(input logic [15:0] fore, input logic [15:0] back,
                                             input logic [1:0] bpp, input logic [7:0] gray,
                                             input logic [7:0] gw, input logic [7:0] fw,
                                             input logic [7:0] rows);
    agb_pkg::cfg_t c;
    c.fg_rgb = fore;
    c.bg_rgb = back;
    c.bpp_log2 = bpp;
    c.gray_level = gray;
    c.glyph_width = gw;
    c.frame_width = fw;
    c.glyph_rows = rows;
    return c;
  endfunction

  // flavor 0: small random glyph, 1: largest sizes, 2: smallest sizes
  function automatic agb_pkg::cfg_t random_settings(input int flavor);
    logic [1:0] bpp;
    logic [7:0] gray;
    logic [7:0] fw;
    bpp = 2'($urandom_range(3));
    case ($urandom_range(2))
      0: gray = 8'd2;
      1: gray = 8'((1 << (1 << bpp)) > 255 ? 255 : (1 << (1 << bpp)));
      default: gray = 8'($urandom_range(255, 2));
    endcase
    fw = 8'($urandom_range(12, 1));
    if (flavor == 1)
      return settings(16'hFFFF, 16'h0000, 2'd0, 8'd255, 8'd255, 8'd255, 8'd255);
    if (flavor == 2)
      return settings(16'h0000, 16'hFFFF, 2'd3, 8'd2, 8'd1, 8'd1, 8'd1);
    return settings(16'($urandom_range(65535)), 16'($urandom_range(65535)), bpp, gray,
                    8'($urandom_range(14, 1)), fw, 8'($urandom_range(6, 1)));
  endfunction

  // Wait for every expected pixel, then let a byte with no pixels finish too.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic load_settings(input agb_pkg::cfg_t c);
    settle();
    put_reg(agb_pkg::REG_FG_RGB, c.fg_rgb);
    put_reg(agb_pkg::REG_BG_RGB, c.bg_rgb);
    put_reg(agb_pkg::REG_BPP_LOG2, {14'h0, c.bpp_log2});
    put_reg(agb_pkg::REG_GRAY_LEVEL, {8'h0, c.gray_level});
    put_reg(agb_pkg::REG_GLYPH_WIDTH, {8'h0, c.glyph_width});
    put_reg(agb_pkg::REG_FRAME_WIDTH, {8'h0, c.frame_width});
    put_reg(agb_pkg::REG_GLYPH_ROWS, {8'h0, c.glyph_rows});
    cfg_we <= 1'b0;
    sb.regs = c;
  endtask

  task automatic send_byte(input logic [7:0] data, input logic start, input logic [11:0] ox,
                           input logic [11:0] oy, output int n);
    int gap;
    gap = 0;
    while (int'($urandom_range(99)) < send_idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= data;
    in_glyph_start <= start;
    in_origin_x <= ox;
    in_origin_y <= oy;
    do @(posedge clk); while (in_stall);
    n = sb.note_byte(data, start, ox, oy);
  endtask

  // Random glyph requests until enough of them have drawn pixels.
  task automatic random_group(input agb_pkg::cfg_t c);
    int pixel_bytes;
    int nbytes;
    int b;
    int n;
    logic [11:0] ox;
    logic [11:0] oy;
    logic [7:0]  data;
    logic        start;
    load_settings(c);
    pixel_bytes = 0;
    while (pixel_bytes < GROUP_PIXEL_BYTES) begin
      nbytes = (int'(c.glyph_rows) * int'(c.frame_width) * (1 << c.bpp_log2) + 7) / 8;
      if (nbytes > GROUP_MAX_BYTES) nbytes = GROUP_MAX_BYTES;
      nbytes += $urandom_range(2);
      ox = ($urandom_range(3) == 0) ? 12'hFFF : 12'($urandom_range(4095));
      oy = ($urandom_range(3) == 0) ? 12'hFFF : 12'($urandom_range(4095));
      for (b = 0; b < nbytes; b++) begin
        // mostly well-formed glyphs; a few missing or stray restarts
        start = (b == 0) ? ($urandom_range(9) != 0) : ($urandom_range(29) == 0);
        case ($urandom_range(7))
          0: data = 8'h00;
          1: data = 8'hFF;
          default: data = 8'($urandom_range(255));
        endcase
        send_byte(data, start, ox, oy, n);
        if (n > 0) pixel_bytes++;
      end
      if ($urandom_range(7) == 0) settle();
    end
  endtask

  initial begin
    int n;
    int i;
    int mode;
    int g;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    send_idle_pct = 13;
    recv_stall_pct = 70;

    // register defaults after reset
    send_byte(8'hFF, 1'b1, 12'h000, 12'h000, n);
    send_byte(8'h00, 1'b0, 12'h000, 12'h000, n);
    send_byte(8'hA5, 1'b0, 12'hFFF, 12'hFFF, n);
    send_byte(8'h5A, 1'b1, 12'hFFF, 12'hFFF, n);

    // alpha thresholds at 8 bpp; glyph wider than frame; bytes past last row
    load_settings(settings(16'hF81F, 16'h07E0, 2'd3, 8'd255, 8'd3, 8'd2, 8'd3));
    send_byte(8'h07, 1'b1, 12'd100, 12'd200, n);
    send_byte(8'h08, 1'b0, 12'd100, 12'd200, n);
    send_byte(8'hF7, 1'b0, 12'd100, 12'd200, n);
    send_byte(8'hF8, 1'b0, 12'd100, 12'd200, n);
    send_byte(8'h00, 1'b0, 12'd100, 12'd200, n);
    send_byte(8'hFF, 1'b0, 12'd100, 12'd200, n);
    send_byte(8'h55, 1'b0, 12'd100, 12'd200, n);
    send_byte(8'hAA, 1'b0, 12'd100, 12'd200, n);

    // 2 bpp with value above the top gray level
    load_settings(settings(16'h0000, 16'hFFFF, 2'd1, 8'd3, 8'd255, 8'd255, 8'd255));
    send_byte(8'hE4, 1'b1, 12'hABC, 12'h543, n);
    send_byte(8'hFF, 1'b0, 12'hABC, 12'h543, n);
    send_byte(8'h1B, 1'b0, 12'hABC, 12'h543, n);

    // gray level 0 and 1 fall back to a divisor of one
    load_settings(settings(16'h1234, 16'hABCD, 2'd3, 8'd0, 8'd4, 8'd4, 8'd4));
    send_byte(8'h01, 1'b1, 12'd7, 12'd9, n);
    send_byte(8'h80, 1'b0, 12'd7, 12'd9, n);
    send_byte(8'hFF, 1'b0, 12'd7, 12'd9, n);
    load_settings(settings(16'h8410, 16'h7BEF, 2'd2, 8'd1, 8'd8, 8'd8, 8'd2));
    send_byte(8'h21, 1'b1, 12'd1, 12'd2, n);
    send_byte(8'hF0, 1'b0, 12'd1, 12'd2, n);

    // zero glyph width, then zero frame width: nothing drawn
    load_settings(settings(16'hFFFF, 16'h0000, 2'd0, 8'd2, 8'd0, 8'd16, 8'd16));
    send_byte(8'hFF, 1'b1, 12'd0, 12'd0, n);
    send_byte(8'h0F, 1'b0, 12'd0, 12'd0, n);
    load_settings(settings(16'hFFFF, 16'h0000, 2'd0, 8'd2, 8'd5, 8'd0, 8'd16));
    send_byte(8'hFF, 1'b1, 12'd0, 12'd0, n);
    send_byte(8'hFF, 1'b0, 12'd0, 12'd0, n);

    // one pixel per row: run the row counter into saturation, no wrap back
    load_settings(settings(16'hFFFF, 16'h0000, 2'd0, 8'd2, 8'd1, 8'd1, 8'd255));
    for (i = 0; i < 66; i++)
      send_byte(8'($urandom_range(255)), i == 0, 12'd50, 12'd60, n);

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 13;
          recv_stall_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_stall_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      for (g = 0; g < 2; g++)
        random_group(random_settings((g == 1) ? 1 + mode % 2 : 0));
    end

    settle();
    if (sb.outstanding() != 0) begin
      $error("%0d expected pixels never arrived", sb.outstanding());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: files.f
design/agb_pkg.sv
design/agb_ctrl.sv
design/agb_dp.sv
design/antialiased_glyph_pixel_blender.sv
tb/tb_antialiased_glyph_pixel_blender.sv
